/* rtl/core/swsab_pkg.sv */
// Shared types, constants and register codes for the sample window spread alarm blinker.
`default_nettype none
package swsab_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned PeriodW = 4;
  localparam int unsigned TickW   = 4;
  localparam int unsigned FillW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 10;

  // Samples per window, legal range 2 to 7.
  localparam logic [FillW-1:0] Window = 3'd5;

  localparam logic [SampleW-1:0] LowLimitRst    = 10'd10;
  localparam logic [SampleW-1:0] HighLimitRst   = 10'd1013;
  localparam logic [SampleW-1:0] SpreadLimitRst = 10'd500;
  localparam logic [PeriodW-1:0] SlowPeriodRst  = 4'd4;

  localparam logic [SampleW-1:0] RunMinRst = 10'd1023;
  localparam logic [SampleW-1:0] RunMaxRst = 10'd0;
  localparam logic [TickW-1:0]   TickMax   = 4'd15;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  localparam logic [CfgIdxW-1:0] RegLowLimit    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHighLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpreadLimit = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSlowPeriod  = 2'd3;

  // Status handed to the blinker for one tick.
  typedef struct packed {
    logic                tick;
    logic                error;
    logic                alarm;
    logic [PeriodW-1:0]  slow_period;
  } blink_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/swsab_blinker.sv */
// LED blink state machine: fast toggle on error, slow toggle on alarm.
`default_nettype none
module swsab_blinker (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire swsab_pkg::blink_ctrl_t ctrl_i,
  output logic                       pin_o
);

  logic                         toggle_q, toggle_d;
  logic                         pin_q, pin_d;
  logic                         first_q, first_d;
  logic [swsab_pkg::TickW-1:0]  tick_q, tick_d, tick_mid;

  always_comb begin
    toggle_d = toggle_q;
    pin_d    = pin_q;
    first_d  = first_q;
    tick_mid = tick_q;
    if (ctrl_i.error) begin
      pin_d    = toggle_q;
      toggle_d = ~toggle_q;
      first_d  = 1'b1;
    end else if (ctrl_i.alarm && (tick_q >= ctrl_i.slow_period)) begin
      // first slow toggle after entering alarm always starts lit
      pin_d    = first_q ? 1'b1 : toggle_q;
      toggle_d = ~pin_d;
      tick_mid = '0;
      first_d  = 1'b0;
    end else if (!ctrl_i.alarm) begin
      pin_d   = 1'b0;
      first_d = 1'b1;
    end
    tick_d = (tick_mid < swsab_pkg::TickMax) ? tick_mid + 1'b1 : tick_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= 1'b0;
      pin_q    <= 1'b0;
      first_q  <= 1'b1;
      tick_q   <= '0;
    end else if (ctrl_i.tick) begin
      toggle_q <= toggle_d;
      pin_q    <= pin_d;
      first_q  <= first_d;
      tick_q   <= tick_d;
    end
  end

  assign pin_o = ctrl_i.tick ? pin_d : pin_q;

endmodule
`default_nettype wire

/* rtl/core/sample_window_spread_alarm_blinker.sv */
// Top level: sample window min/max tracking, limit and spread alarms, LED blinker.
`default_nettype none
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: cmd_i selects a
//   converter sample (cmd 0, sample_i) or a blink tick (cmd 1). A request is taken
//   on a clock edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   request: led, error, alarm, window_done and the window min/max (zero unless
//   window_done is set).
//   Config channel (cfg_valid_i / cfg_ready_o, always ready) writes low_limit (0),
//   high_limit (1), spread_limit (2) and slow_period (3); write only while idle.
// Timing:
//   A request is held in the input register, then the state update and result
//   are computed in one pass into the output register: throughput one request
//   per cycle while out_stall_i does not hold a result, set by the single compare/update pass.
// Reset (rst_ni low, async): limits go to 10/1013/500/4, the window restarts
//   empty, flags and LED clear, both pipeline registers empty.
// Stall: while out_stall_i holds a result, the input register stays full and
//   in_stall_o rises once it is occupied; nothing is dropped or repeated.
module sample_window_spread_alarm_blinker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            cmd_i,
  input  wire logic [swsab_pkg::SampleW-1:0]   sample_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 led_o,
  output logic                                 error_o,
  output logic                                 alarm_o,
  output logic                                 window_done_o,
  output logic [swsab_pkg::SampleW-1:0]        window_min_o,
  output logic [swsab_pkg::SampleW-1:0]        window_max_o,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [swsab_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [swsab_pkg::CfgDatW-1:0]   cfg_data_i
);

  localparam int unsigned SW = swsab_pkg::SampleW;

  // configuration registers
  logic [SW-1:0]                 low_q, high_q, spread_q;
  logic [swsab_pkg::PeriodW-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= swsab_pkg::LowLimitRst;
      high_q   <= swsab_pkg::HighLimitRst;
      spread_q <= swsab_pkg::SpreadLimitRst;
      period_q <= swsab_pkg::SlowPeriodRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swsab_pkg::RegLowLimit:    low_q    <= cfg_data_i[SW-1:0];
        swsab_pkg::RegHighLimit:   high_q   <= cfg_data_i[SW-1:0];
        swsab_pkg::RegSpreadLimit: spread_q <= cfg_data_i[SW-1:0];
        swsab_pkg::RegSlowPeriod:  period_q <= cfg_data_i[swsab_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic          in_vld_q;
  logic          cmd_q;
  logic [SW-1:0] sample_q;
  logic          out_free;
  logic          advance;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q    <= cmd_i;
      sample_q <= sample_i;
    end
  end

  // window state
  logic [swsab_pkg::FillW-1:0] fill_q, fill_d, fill_inc;
  logic [SW-1:0]               min_q, min_d, min_new;
  logic [SW-1:0]               max_q, max_d, max_new;
  logic                        err_q, err_d;
  logic                        alm_q, alm_d;
  logic                        done;
  logic                        is_sample;

  assign is_sample = advance && (cmd_q == swsab_pkg::CmdSample);

  always_comb begin
    min_new  = (sample_q < min_q) ? sample_q : min_q;
    max_new  = (sample_q > max_q) ? sample_q : max_q;
    fill_inc = fill_q + 1'b1;
    done     = (fill_inc >= swsab_pkg::Window);
    err_d    = (sample_q < low_q) || (sample_q > high_q);
    alm_d    = alm_q;
    if (done) begin
      // an empty-window case (max below min) never alarms
      alm_d = (max_new >= min_new) && ((max_new - min_new) > spread_q);
      fill_d = '0;
      min_d  = swsab_pkg::RunMinRst;
      max_d  = swsab_pkg::RunMaxRst;
    end else begin
      fill_d = fill_inc;
      min_d  = min_new;
      max_d  = max_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      min_q  <= swsab_pkg::RunMinRst;
      max_q  <= swsab_pkg::RunMaxRst;
      err_q  <= 1'b0;
      alm_q  <= 1'b0;
    end else if (is_sample) begin
      fill_q <= fill_d;
      min_q  <= min_d;
      max_q  <= max_d;
      err_q  <= err_d;
      alm_q  <= alm_d;
    end
  end

  // LED blinker sees the flags as they stand before the tick
  swsab_pkg::blink_ctrl_t blink_ctrl;
  logic                   pin_now;

  assign blink_ctrl.tick        = advance && (cmd_q == swsab_pkg::CmdTick);
  assign blink_ctrl.error       = err_q;
  assign blink_ctrl.alarm       = alm_q;
  assign blink_ctrl.slow_period = period_q;

  swsab_blinker u_blinker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (blink_ctrl),
    .pin_o  (pin_now)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_o <= pin_now;
      if (cmd_q == swsab_pkg::CmdSample) begin
        error_o       <= err_d;
        alarm_o       <= alm_d;
        window_done_o <= done;
        window_min_o  <= done ? min_new : '0;
        window_max_o  <= done ? max_new : '0;
      end else begin
        error_o       <= err_q;
        alarm_o       <= alm_q;
        window_done_o <= 1'b0;
        window_min_o  <= '0;
        window_max_o  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the sample window spread alarm blinker.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycle budget for the whole run, with a wide margin over the slowest legal run.
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 80;

  // One expected result, field for field as the block reports it.
  typedef struct packed {
    logic                          led;
    logic                          error;
    logic                          alarm;
    logic                          done;
    logic [swsab_pkg::SampleW-1:0] wmin;
    logic [swsab_pkg::SampleW-1:0] wmax;
  } status_t;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          cmd_i       = swsab_pkg::CmdSample;
  logic [swsab_pkg::SampleW-1:0] sample_i    = '0;
  logic                          out_stall_i = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic [swsab_pkg::CfgIdxW-1:0] cfg_index_i = swsab_pkg::RegLowLimit;
  logic [swsab_pkg::CfgDatW-1:0] cfg_data_i  = '0;

  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          led_o;
  logic                          error_o;
  logic                          alarm_o;
  logic                          window_done_o;
  logic [swsab_pkg::SampleW-1:0] window_min_o;
  logic [swsab_pkg::SampleW-1:0] window_max_o;
  logic                          cfg_ready_o;

  sample_window_spread_alarm_blinker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .led_o         (led_o),
    .error_o       (error_o),
    .alarm_o       (alarm_o),
    .window_done_o (window_done_o),
    .window_min_o  (window_min_o),
    .window_max_o  (window_max_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the block's registers and window/blink
  // state, updated once per accepted request.
  // ---------------------------------------------------------------------------
  logic [swsab_pkg::SampleW-1:0] lim_low, lim_high, lim_spread;
  logic [swsab_pkg::PeriodW-1:0] slow_period;
  logic [swsab_pkg::FillW-1:0]   win_fill;
  logic [swsab_pkg::SampleW-1:0] win_min, win_max;
  logic                          err_flag, alm_flag;
  logic                          blink_phase;   // level the LED takes on the next toggle
  logic                          led_level;
  logic [swsab_pkg::TickW-1:0]   tick_cnt;
  logic                          slow_restart;  // next slow toggle starts from lit

  status_t pending_status[$];        // expected results, oldest first
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Rate knobs for random idling on both sides (percent of decisions).
  int unsigned stall_pct = 30;
  int unsigned gap_pct   = 30;
  bit          hold_req  = 1'b0;     // asks the receiver for one long hold-off

  task automatic reset_predictor();
    lim_low      = swsab_pkg::LowLimitRst;
    lim_high     = swsab_pkg::HighLimitRst;
    lim_spread   = swsab_pkg::SpreadLimitRst;
    slow_period  = swsab_pkg::SlowPeriodRst;
    win_fill     = '0;
    win_min      = swsab_pkg::RunMinRst;
    win_max      = swsab_pkg::RunMaxRst;
    err_flag     = 1'b0;
    alm_flag     = 1'b0;
    blink_phase  = 1'b0;
    led_level    = 1'b0;
    tick_cnt     = '0;
    slow_restart = 1'b1;
  endtask

  // Works out the result of one request and queues it.
  task automatic predict_status(input logic cmd, input logic [swsab_pkg::SampleW-1:0] s);
    status_t r;
    r = '0;
    if (cmd == swsab_pkg::CmdSample) begin
      // limits are compared as given, even when crossed
      err_flag = (s < lim_low) || (s > lim_high);
      if (s < win_min) win_min = s;
      if (s > win_max) win_max = s;
      win_fill = win_fill + 1'b1;
      if (win_fill >= swsab_pkg::Window) begin
        r.done   = 1'b1;
        r.wmin   = win_min;
        r.wmax   = win_max;
        alm_flag = (win_max >= win_min) && ((win_max - win_min) > lim_spread);
        win_fill = '0;
        win_min  = swsab_pkg::RunMinRst;
        win_max  = swsab_pkg::RunMaxRst;
      end
    end else begin
      if (err_flag) begin
        // fast blink: toggle on every tick
        led_level    = blink_phase;
        blink_phase  = ~blink_phase;
        slow_restart = 1'b1;
      end else if (alm_flag && tick_cnt >= slow_period) begin
        // slow blink; a fresh alarm starts lit
        if (slow_restart) blink_phase = 1'b1;
        led_level    = blink_phase;
        blink_phase  = ~blink_phase;
        tick_cnt     = '0;
        slow_restart = 1'b0;
      end else if (!alm_flag) begin
        led_level    = 1'b0;
        slow_restart = 1'b1;
      end
      if (tick_cnt < swsab_pkg::TickMax) tick_cnt = tick_cnt + 1'b1;
    end
    r.led   = led_level;
    r.error = err_flag;
    r.alarm = alm_flag;
    pending_status.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    return ($urandom_range(0, 11) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Offers one request and returns on the edge it is taken. Valid is left
  // high so a following request goes out back to back.
  task automatic send_request(input logic cmd, input logic [swsab_pkg::SampleW-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      cmd_i      <= 1'($urandom);
      sample_i   <= swsab_pkg::SampleW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_status(cmd, s);
  endtask

  // Drops valid and waits until every expected result is back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input logic [swsab_pkg::CfgIdxW-1:0] idx,
                           input logic [swsab_pkg::CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      swsab_pkg::RegLowLimit:    lim_low     = data[swsab_pkg::SampleW-1:0];
      swsab_pkg::RegHighLimit:   lim_high    = data[swsab_pkg::SampleW-1:0];
      swsab_pkg::RegSpreadLimit: lim_spread  = data[swsab_pkg::SampleW-1:0];
      swsab_pkg::RegSlowPeriod:  slow_period = data[swsab_pkg::PeriodW-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers with the block drained. Upper bits of the
  // period word are don't-care and are passed through as given.
  task automatic set_config(input logic [swsab_pkg::SampleW-1:0] low,
                            input logic [swsab_pkg::SampleW-1:0] high,
                            input logic [swsab_pkg::SampleW-1:0] spread,
                            input logic [swsab_pkg::CfgDatW-1:0] period_word);
    wait_idle();
    write_reg(swsab_pkg::RegLowLimit, low);
    write_reg(swsab_pkg::RegHighLimit, high);
    write_reg(swsab_pkg::RegSpreadLimit, spread);
    write_reg(swsab_pkg::RegSlowPeriod, period_word);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned free_left  = 0;

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (free_left != 0) begin
      free_left   = free_left - 1;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      free_left   = $urandom_range(0, 24);
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(input string name,
                                      input logic [swsab_pkg::SampleW-1:0] want,
                                      input logic [swsab_pkg::SampleW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Each accepted result is matched against the oldest expectation.
  status_t want_status;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $error("result with no pending request: led %0d error %0d alarm %0d done %0d",
               led_o, error_o, alarm_o, window_done_o);
        fail_count++;
      end else begin
        want_status = pending_status.pop_front();
        check_field("led", want_status.led, led_o);
        check_field("error", want_status.error, error_o);
        check_field("alarm", want_status.alarm, alarm_o);
        check_field("window_done", want_status.done, window_done_o);
        check_field("window_min", want_status.wmin, window_min_o);
        check_field("window_max", want_status.wmax, window_max_o);
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** sample_window_spread_alarm_blinker: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset limits: boundary samples, both window extremes, fast then slow blink.
  task automatic test_limits_and_windows();
    send_request(swsab_pkg::CmdSample, 10'd0);     // below low limit
    send_request(swsab_pkg::CmdSample, 10'd1023);  // above high limit
    send_request(swsab_pkg::CmdSample, swsab_pkg::LowLimitRst);
    send_request(swsab_pkg::CmdSample, swsab_pkg::HighLimitRst);
    send_request(swsab_pkg::CmdSample, 10'd9);     // window of 0..1023 closes, alarm
    send_request(swsab_pkg::CmdTick, 10'd1023);    // error wins over alarm: fast blink
    send_request(swsab_pkg::CmdTick, 10'd0);
    send_request(swsab_pkg::CmdSample, 10'd1014);
    repeat (4) send_request(swsab_pkg::CmdSample, 10'd500);  // spread 514, no error
    // slow blink, starts lit
    repeat (4) send_request(swsab_pkg::CmdTick, swsab_pkg::SampleW'($urandom));
  endtask

  // Crossed limits, zero period, and a spread equal to its limit.
  task automatic test_extreme_settings();
    set_config(10'd1023, 10'd0, 10'd0, {6'h3F, 4'd0});
    send_request(swsab_pkg::CmdSample, 10'd5);
    send_request(swsab_pkg::CmdSample, 10'd6);
    send_request(swsab_pkg::CmdSample, 10'd5);
    send_request(swsab_pkg::CmdSample, 10'd5);
    send_request(swsab_pkg::CmdTick, 10'd0);
    set_config(10'd0, 10'd1023, 10'd0, {6'h15, 4'd0});
    send_request(swsab_pkg::CmdSample, 10'd6);     // spread 1 above 0: alarm, no error
    // toggles every tick
    repeat (3) send_request(swsab_pkg::CmdTick, swsab_pkg::SampleW'($urandom));
    set_config(10'd0, 10'd1023, 10'd1023, {6'h2A, 4'd15});
    send_request(swsab_pkg::CmdSample, 10'd0);
    send_request(swsab_pkg::CmdSample, 10'd1023);
    repeat (3) send_request(swsab_pkg::CmdSample, 10'd0);   // spread 1023 is not above 1023
  endtask

  function automatic logic [swsab_pkg::SampleW-1:0] pick_setting(input int unsigned lo,
                                                                 input int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return swsab_pkg::SampleW'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [swsab_pkg::SampleW-1:0] in_limits();
    return swsab_pkg::SampleW'($urandom_range(lim_low, lim_high));
  endfunction

  // Mostly whole windows of in-limit samples (narrow or wide) and tick bursts
  // long enough to reach any slow period; a little out-of-limit noise.
  task automatic run_random_phase(input int unsigned n_items, input bit quiet);
    int unsigned                   sent;
    int unsigned                   kind;
    bit                            wide;
    logic [swsab_pkg::SampleW-1:0] base;
    logic [swsab_pkg::SampleW-1:0] v;
    set_config(pick_setting(0, 200), pick_setting(800, 1023), pick_setting(0, 1023),
               swsab_pkg::CfgDatW'($urandom));
    stall_pct = quiet ? 0 : 30;
    gap_pct   = quiet ? 0 : 30;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        wide = 1'($urandom);
        base = in_limits();
        for (int k = 0; k < swsab_pkg::Window; k++) begin
          if ($urandom_range(0, 9) == 0) v = swsab_pkg::SampleW'($urandom);
          else if (wide) v = in_limits();
          else v = base ^ swsab_pkg::SampleW'($urandom_range(0, 7));
          send_request(swsab_pkg::CmdSample, v);
          sent++;
          if ($urandom_range(0, 4) == 0) begin
            send_request(swsab_pkg::CmdTick, swsab_pkg::SampleW'($urandom));
            sent++;
          end
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 18)) begin
          send_request(swsab_pkg::CmdTick, swsab_pkg::SampleW'($urandom));
          sent++;
        end
      end else begin
        send_request(swsab_pkg::CmdSample, swsab_pkg::SampleW'($urandom));
        sent++;
      end
    end
    stall_pct = 30;
    gap_pct   = 30;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) run_random_phase(110, p == 2);
  endtask

  // Receiver holds off while requests keep coming: the block fills and
  // must stall its input without losing or repeating anything.
  task automatic test_output_backpressure();
    stall_pct = 0;
    gap_pct   = 0;
    hold_req  = 1'b1;
    repeat (30) send_request(($urandom_range(0, 2) == 0) ? swsab_pkg::CmdTick
                                                         : swsab_pkg::CmdSample,
                             swsab_pkg::SampleW'($urandom));
    stall_pct = 30;
    gap_pct   = 30;
  endtask

  // Sender stops mid-stream until everything has drained, then resumes.
  task automatic test_pause_until_drained();
    repeat (12) send_request(1'($urandom), in_limits());
    wait_idle();
    repeat (12) send_request(1'($urandom), in_limits());
  endtask

  initial begin
    reset_predictor();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_limits_and_windows();
    test_extreme_settings();
    test_random_traffic();
    test_output_backpressure();
    test_pause_until_drained();
    wait_idle();
    // let any stray extra result show up before the verdict
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** sample_window_spread_alarm_blinker: PASSED **");
    end else begin
      $display("** sample_window_spread_alarm_blinker: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
